### rtl/core/assert_macros.svh
// assertion macros shared by the rtl/core modules
// expects clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check on the rising clock, off during reset
`define MVM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// overlapping implication, same cycle
`define MVM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// non-overlapping implication, next cycle
`define MVM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/mvm_pkg.sv
// types and constants for the matrix vector multiply block
// no dependencies

package mvm_pkg;

  localparam int unsigned MAX_COLS = 256;
  localparam int unsigned MAX_ROWS = 4096;

  // store address and position widths
  localparam int unsigned COL_W  = $clog2(MAX_COLS);
  localparam int unsigned ROW_W  = $clog2(MAX_ROWS);
  // counts need one more bit to hold the maximum itself
  localparam int unsigned NCOL_W = COL_W + 1;
  localparam int unsigned NROW_W = ROW_W + 1;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned CFG_W   = 13;
  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_COLS = 1'b0,
    CFG_NUM_ROWS = 1'b1
  } mvm_cfg_idx_e;

  typedef enum logic [0:0] {
    CMD_VEC_WRITE = 1'b0,
    CMD_MAT_ELEM  = 1'b1
  } mvm_cmd_e;

  typedef struct packed {
    logic               command;
    logic [7:0]         element_index;
    logic signed [31:0] data_value;
  } mvm_in_req_t;

  typedef struct packed {
    logic signed [31:0] row_sum;
    logic [11:0]        row_index;
    logic               last_row;
  } mvm_out_req_t;

  // one accepted item as handed from the sequencer to the datapath
  typedef struct packed {
    logic              valid;
    logic              is_mat;
    logic [COL_W-1:0]  addr;
    logic [DATA_W-1:0] data;
    logic              end_row;
    logic [11:0]       row_index;
    logic              last_row;
  } mvm_issue_t;

endpackage

### rtl/core/mvm_datapath.sv
// vector store, multiply and accumulate pipeline with output register
// depends on mvm_pkg and assert_macros.svh

`include "assert_macros.svh"

module mvm_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mvm_pkg::mvm_issue_t   issue_i,
  output logic                  issue_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output mvm_pkg::mvm_out_req_t out_req_o
);
  import mvm_pkg::*;

  logic [DATA_W-1:0] vec_mem [MAX_COLS];
  logic [DATA_W-1:0] rdata_q;

  logic              s1_valid_q, s1_valid_d;
  logic [DATA_W-1:0] s1_data_q;
  logic              s1_end_row_q;
  logic [11:0]       s1_row_q;
  logic              s1_last_q;

  logic              s2_valid_q, s2_valid_d;
  logic [DATA_W-1:0] s2_prod_q;
  logic              s2_end_row_q;
  logic [11:0]       s2_row_q;
  logic              s2_last_q;

  logic [DATA_W-1:0] acc_q, acc_d;
  logic [DATA_W-1:0] acc_sum;
  logic [DATA_W-1:0] prod;

  logic              out_valid_q, out_valid_d;
  mvm_out_req_t      out_q;

  logic out_blocked, s2_move, s2_fire, s1_free, issue_fire, wr_en, rd_en;

  assign out_blocked = out_valid_q && !out_ready_i;
  // s2 only waits when it carries a row end and the output slot is taken
  assign s2_move     = !s2_valid_q || !(s2_end_row_q && out_blocked);
  assign s2_fire     = s2_valid_q && s2_move;
  assign s1_free     = !s1_valid_q || s2_move;

  assign issue_ready_o = s1_free;
  assign issue_fire    = issue_i.valid && s1_free;
  assign wr_en         = issue_fire && !issue_i.is_mat;
  assign rd_en         = issue_fire && issue_i.is_mat;

  // synchronous store, one access per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      vec_mem[issue_i.addr] <= issue_i.data;
    end
    if (rd_en) begin
      rdata_q <= vec_mem[issue_i.addr];
    end
  end

  assign prod    = s1_data_q * rdata_q;
  assign acc_sum = acc_q + s2_prod_q;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_free) begin
      s1_valid_d = rd_en;
    end
    s2_valid_d = s2_valid_q;
    if (s2_move) begin
      s2_valid_d = s1_valid_q;
    end
    acc_d = acc_q;
    if (s2_fire) begin
      acc_d = s2_end_row_q ? '0 : acc_sum;
    end
    out_valid_d = out_valid_q && !out_ready_i;
    if (s2_fire && s2_end_row_q) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      s2_valid_q  <= s2_valid_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      s1_data_q    <= issue_i.data;
      s1_end_row_q <= issue_i.end_row;
      s1_row_q     <= issue_i.row_index;
      s1_last_q    <= issue_i.last_row;
    end
    if (s2_move && s1_valid_q) begin
      s2_prod_q    <= prod;
      s2_end_row_q <= s1_end_row_q;
      s2_row_q     <= s1_row_q;
      s2_last_q    <= s1_last_q;
    end
    if (s2_fire && s2_end_row_q) begin
      out_q.row_sum   <= acc_sum;
      out_q.row_index <= s2_row_q;
      out_q.last_row  <= s2_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  `MVM_ASSERT_NXT(a_s2_hold, s2_valid_q && !s2_move, s2_valid_q && $stable(s2_prod_q),
                  "stalled product lost")
  `MVM_ASSERT_NXT(a_rdata_hold, s1_valid_q && !s2_move, $stable(rdata_q),
                  "store read data changed under a held stage")
  `MVM_ASSERT_IMP(a_no_overwrite, s2_fire && s2_end_row_q, !out_blocked,
                  "row sum loaded over a pending result")

endmodule

### rtl/core/matrix_vector_multiply.sv
// top level of the streamed signed 32-bit matrix vector multiply
// depends on mvm_pkg, mvm_datapath and assert_macros.svh
//
// usage
//   config port: cfg_we_i with cfg_idx_i selects num_cols (0) or num_rows (1);
//   counts of zero read as one, counts above the maximum saturate (num_cols
//   uses only cfg_wdata_i[8:0]). write only while the block is idle
//   input channel (in_valid_i / in_ready_o / in_req_i): a request with
//   command CMD_VEC_WRITE stores data_value at element_index in the vector
//   store; CMD_MAT_ELEM streams the next matrix element in row-major order
//   output channel (out_valid_o / out_ready_i / out_req_o): one request per
//   finished row with the wrapped row sum, its row index and a last-row flag
//   path: store read stage s1, product stage s2, then the output register
//   throughput: one request per cycle unless stalled, vector writes and
//   matrix elements alike; the single-port vector store does one write or
//   one read a cycle
//   stalls: a row end waiting behind a held output register stops the
//   pipeline; elements that end no row keep flowing while a result waits
//   reset: positions and the running sum clear, counts go to one; the vector
//   store is not cleared and must be written before use

`include "assert_macros.svh"

module matrix_vector_multiply (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mvm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mvm_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  mvm_pkg::mvm_in_req_t         in_req_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output mvm_pkg::mvm_out_req_t        out_req_o
);
  import mvm_pkg::*;

  // configuration, held already clamped to the legal range
  logic [NCOL_W-1:0] cols_q, cols_d;
  logic [NROW_W-1:0] rows_q, rows_d;
  logic [NCOL_W-1:0] cfg_cols;
  logic [NROW_W-1:0] cfg_rows;

  // stream position
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;

  logic              in_fire, is_mat, end_row, last_row, addr_ok;
  logic [NCOL_W-1:0] col_next;
  logic [NROW_W-1:0] row_next;
  logic              issue_ready;
  mvm_issue_t        issue;

  assign cfg_cols = cfg_wdata_i[NCOL_W-1:0];
  assign cfg_rows = cfg_wdata_i[NROW_W-1:0];

  always_comb begin
    cols_d = cols_q;
    rows_d = rows_q;
    if (cfg_we_i) begin
      case (mvm_cfg_idx_e'(cfg_idx_i))
        CFG_NUM_COLS: begin
          if (cfg_cols == '0) begin
            cols_d = NCOL_W'(1);
          end else if (cfg_cols > NCOL_W'(MAX_COLS)) begin
            cols_d = NCOL_W'(MAX_COLS);
          end else begin
            cols_d = cfg_cols;
          end
        end
        CFG_NUM_ROWS: begin
          if (cfg_rows == '0) begin
            rows_d = NROW_W'(1);
          end else if (cfg_rows > NROW_W'(MAX_ROWS)) begin
            rows_d = NROW_W'(MAX_ROWS);
          end else begin
            rows_d = cfg_rows;
          end
        end
        default: begin
          cols_d = cols_q;
          rows_d = rows_q;
        end
      endcase
    end
  end

  // a row ends once the column position reaches or passes the last column
  assign is_mat   = (in_req_i.command == CMD_MAT_ELEM);
  assign col_next = NCOL_W'(col_q) + NCOL_W'(1);
  assign row_next = NROW_W'(row_q) + NROW_W'(1);
  assign end_row  = (col_next >= cols_q);
  assign last_row = (row_next >= rows_q);
  // element writes beyond the store are dropped
  assign addr_ok  = (NCOL_W'(in_req_i.element_index) < NCOL_W'(MAX_COLS));

  assign in_ready_o = issue_ready;
  assign in_fire    = in_valid_i && issue_ready;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_fire && is_mat) begin
      if (end_row) begin
        col_d = '0;
        row_d = last_row ? '0 : row_next[ROW_W-1:0];
      end else begin
        col_d = col_next[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= NCOL_W'(1);
      rows_q <= NROW_W'(1);
      col_q  <= '0;
      row_q  <= '0;
    end else begin
      cols_q <= cols_d;
      rows_q <= rows_d;
      col_q  <= col_d;
      row_q  <= row_d;
    end
  end

  // matrix elements read the store at their column, vector writes use the index
  always_comb begin
    issue.valid     = in_valid_i && (is_mat || addr_ok);
    issue.is_mat    = is_mat;
    issue.addr      = is_mat ? col_q : COL_W'(in_req_i.element_index);
    issue.data      = in_req_i.data_value;
    issue.end_row   = end_row;
    issue.row_index = 12'(row_q);
    issue.last_row  = last_row;
  end

  mvm_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .issue_i       (issue),
    .issue_ready_o (issue_ready),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_req_o     (out_req_o)
  );

  `MVM_ASSERT_NXT(a_row_end_clears_col, in_fire && is_mat && end_row, col_q == '0,
                  "column position not cleared at row end")
  `MVM_ASSERT_NXT(a_matrix_end_clears_row, in_fire && is_mat && end_row && last_row,
                  row_q == '0, "row position not cleared at matrix end")
  `MVM_ASSERT(a_counts_legal, (cols_q != '0) && (cols_q <= NCOL_W'(MAX_COLS)) &&
              (rows_q != '0) && (rows_q <= NROW_W'(MAX_ROWS)), "count out of range")

endmodule
